// File: rtl/mi3_pkg.sv
`default_nettype none
package mi3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EW  = 32;                 // element width
  localparam int QW  = 32;                 // quotient bits produced by a lane
  localparam int PW  = 2 * EW;             // element product
  localparam int CW  = PW + 1;             // signed cofactor
  localparam int MW  = PW + EW;            // determinant magnitude
  localparam int DW  = MW + 1;             // signed determinant
  localparam int RW  = DW + QW + 1;        // lane remainder
  localparam int FLW = 31;                 // det_floor width
  localparam int NSH = 2 * FRAC_BITS + 1;  // numerator shift
  localparam int NL  = 9;                  // lanes, one per element

  typedef logic [NL-1:0][EW-1:0] mat_t;

  typedef struct packed {
    logic valid;
    logic singular;
  } ctl_t;

  typedef struct packed {
    logic [RW-1:0] num;
    logic [DW-1:0] den;
    logic          ovf;
    logic          neg;
  } lane_in_t;

  typedef struct packed {
    logic [QW-1:0] q;
    logic          ovf;
    logic          neg;
  } lane_res_t;

  // adj[k] = m[i0]*m[i1] - m[i2]*m[i3]
  localparam logic [3:0] COF_IDX [NL][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage
`default_nettype wire

// File: rtl/mi3_if.sv
`default_nettype none
interface mi3_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] in_r0c0, in_r0c1, in_r0c2;
  logic signed [31:0] in_r1c0, in_r1c1, in_r1c2;
  logic signed [31:0] in_r2c0, in_r2c1, in_r2c2;
  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface mi3_out_if;
  logic valid;
  logic ready;
  logic singular;
  logic signed [31:0] out_r0c0, out_r0c1, out_r0c2;
  logic signed [31:0] out_r1c0, out_r1c1, out_r1c2;
  logic signed [31:0] out_r2c0, out_r2c1, out_r2c2;
  modport source (output valid, singular, out_r0c0, out_r0c1, out_r0c2, out_r1c0,
                  out_r1c1, out_r1c2, out_r2c0, out_r2c1, out_r2c2, input ready);
  modport sink (input valid, singular, out_r0c0, out_r0c1, out_r0c2, out_r1c0,
                out_r1c1, out_r1c2, out_r2c0, out_r2c1, out_r2c2, output ready);
endinterface

interface mi3_cfg_if;
  logic valid;
  logic ready;
  logic [30:0] det_floor;
  modport source (output valid, det_floor, input ready);
  modport sink (input valid, det_floor, output ready);
endinterface
`default_nettype wire

// File: rtl/mi3_front.sv
`default_nettype none
module mi3_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire mi3_pkg::mat_t         m,
  input  wire logic [mi3_pkg::FLW-1:0] det_floor,
  output mi3_pkg::lane_in_t          lin [mi3_pkg::NL],
  output mi3_pkg::ctl_t              ctl
);
  import mi3_pkg::*;

  logic signed [PW-1:0] p0 [NL];
  logic signed [PW-1:0] p1 [NL];
  logic signed [CW-1:0] cof2 [NL];
  logic signed [CW-1:0] cof3 [NL];
  logic signed [CW-1:0] cof4 [NL];
  logic signed [CW-1:0] cof5 [NL];
  logic signed [EW-1:0] row1 [3];
  logic signed [EW-1:0] row2 [3];
  logic [PW-1:0] pl [3];
  logic [PW-1:0] ph [3];
  logic          tneg [3];
  logic signed [DW-1:0] term [3];
  logic signed [DW-1:0] det;
  logic [4:0] v;

  // stage 1: element products
  for (genvar k = 0; k < NL; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        p0[k] <= $signed(m[COF_IDX[k][0]]) * $signed(m[COF_IDX[k][1]]);
        p1[k] <= $signed(m[COF_IDX[k][2]]) * $signed(m[COF_IDX[k][3]]);
      end
    end
  end

  // stage 2: cofactors
  for (genvar k = 0; k < NL; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        cof2[k] <= CW'(p0[k]) - CW'(p1[k]);
        cof3[k] <= cof2[k];
        cof4[k] <= cof3[k];
        cof5[k] <= cof4[k];
      end
    end
  end

  // stages 3 to 4: first row times cofactor halves, two 64-bit partial products
  for (genvar t = 0; t < 3; t++) begin : g_term
    logic [EW-1:0] amag;
    logic [PW-1:0] cmag;
    logic [MW-1:0] tmag;
    always_comb begin
      amag = row2[t][EW-1] ? EW'(-row2[t]) : EW'(row2[t]);
      cmag = cof2[3*t][CW-1] ? PW'(-cof2[3*t]) : PW'(cof2[3*t]);
      tmag = {ph[t], {EW{1'b0}}} + MW'(pl[t]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        row1[t] <= $signed(m[t]);
        row2[t] <= row1[t];
        pl[t]   <= PW'(amag) * PW'(cmag[EW-1:0]);
        ph[t]   <= PW'(amag) * PW'(cmag[PW-1:EW]);
        tneg[t] <= row2[t][EW-1] ^ cof2[3*t][CW-1];
        term[t] <= tneg[t] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
      end
    end
  end

  // stage 5: determinant
  always_ff @(posedge clk) begin
    if (en) det <= term[0] + term[1] + term[2];
  end

  // stage 6: floor test and divider operands
  logic [MW-1:0] dabs;
  logic [MW-1:0] fl;
  always_comb begin
    dabs = det[DW-1] ? MW'(-det) : MW'(det);
    fl   = MW'(det_floor) << (2 * FRAC_BITS);
  end

  for (genvar k = 0; k < NL; k++) begin : g_op
    logic [PW-1:0] cm;
    logic [RW-1:0] num;
    logic [DW-1:0] den;
    always_comb begin
      cm  = cof5[k][CW-1] ? PW'(-cof5[k]) : PW'(cof5[k]);
      num = (RW'(cm) << NSH) + RW'(dabs);
      den = {dabs, 1'b0};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lin[k].num <= num;
        lin[k].den <= den;
        lin[k].ovf <= num >= (RW'(den) << QW);
        lin[k].neg <= cof5[k][CW-1] ^ det[DW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v   <= '0;
      ctl <= '0;
    end else if (en) begin
      v   <= {v[3:0], in_valid};
      ctl.valid    <= v[4];
      ctl.singular <= dabs <= fl;
    end
  end

endmodule
`default_nettype wire

// File: rtl/mi3_lane.sv
`default_nettype none
module mi3_lane (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire mi3_pkg::lane_in_t  lin,
  output mi3_pkg::lane_res_t      res
);
  import mi3_pkg::*;

  logic [RW-1:0] rem [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic          ov  [QW+1];
  logic          ng  [QW+1];
  logic [DW-1:0] dn  [QW];

  assign rem[0] = lin.num;
  assign quo[0] = '0;
  assign ov[0]  = lin.ovf;
  assign ng[0]  = lin.neg;
  assign dn[0]  = lin.den;

  // divisor travels with its numerator
  for (genvar s = 0; s < QW-1; s++) begin : g_den
    always_ff @(posedge clk) begin
      if (en) dn[s+1] <= dn[s];
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [RW-1:0] dsh;
    logic          ge;
    always_comb begin
      dsh = RW'(dn[s]) << (QW - 1 - s);
      ge  = rem[s] >= dsh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? rem[s] - dsh : rem[s];
        quo[s+1] <= {quo[s][QW-2:0], ge};
        ov[s+1]  <= ov[s];
        ng[s+1]  <= ng[s];
      end
    end
  end

  assign res.q   = quo[QW];
  assign res.ovf = ov[QW];
  assign res.neg = ng[QW];

endmodule
`default_nettype wire

// File: rtl/mi3_merge.sv
`default_nettype none
module mi3_merge (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire mi3_pkg::ctl_t      ctl,
  input  wire mi3_pkg::lane_res_t res [mi3_pkg::NL],
  mi3_out_if.source               out
);
  import mi3_pkg::*;

  logic [EW-1:0] e [NL];

  for (genvar k = 0; k < NL; k++) begin : g_sat
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    always_comb begin
      lim = res[k].neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      mag = (res[k].ovf || res[k].q > lim) ? lim : res[k].q;
      if (ctl.singular) e[k] = '0;
      else e[k] = res[k].neg ? EW'(-mag) : EW'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.singular <= ctl.singular;
      out.out_r0c0 <= e[0];
      out.out_r0c1 <= e[1];
      out.out_r0c2 <= e[2];
      out.out_r1c0 <= e[3];
      out.out_r1c1 <= e[4];
      out.out_r1c2 <= e[5];
      out.out_r2c0 <= e[6];
      out.out_r2c1 <= e[7];
      out.out_r2c2 <= e[8];
    end
  end

endmodule
`default_nettype wire

// File: rtl/matrix_3x3_inverse_core.sv
`default_nettype none
// 3x3 Q16.16 matrix inverse by adjugate over determinant, one matrix per cycle.
// From input transfer to result a matrix passes through products, cofactors,
// first-row terms, determinant, and floor test with rounded divider operands,
// then restoring division (one quotient bit per stage in each of nine lanes, one
// lane per element), then saturation and output register. The whole pipeline moves
// together and holds while a result waits to be taken. A determinant whose
// magnitude is at or below det_floor flags singular with all elements zero.
module matrix_3x3_inverse_core (
  input wire logic  clk,
  input wire logic  rst,
  mi3_in_if.sink    in,
  mi3_out_if.source out,
  mi3_cfg_if.sink   cfg
);
  import mi3_pkg::*;

  logic [FLW-1:0] det_floor;
  logic           en;
  mat_t           m;
  lane_in_t       lin [NL];
  lane_res_t      res [NL];
  ctl_t           cp  [QW+1];

  assign en        = !out.valid || out.ready;
  assign in.ready  = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) det_floor <= '0;
    else if (cfg.valid) det_floor <= cfg.det_floor;
  end

  assign m = {in.in_r2c2, in.in_r2c1, in.in_r2c0, in.in_r1c2, in.in_r1c1,
              in.in_r1c0, in.in_r0c2, in.in_r0c1, in.in_r0c0};

  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in.valid),
    .m         (m),
    .det_floor (det_floor),
    .lin       (lin),
    .ctl       (cp[0])
  );

  for (genvar k = 0; k < NL; k++) begin : g_lane
    mi3_lane u_lane (
      .clk (clk),
      .en  (en),
      .lin (lin[k]),
      .res (res[k])
    );
  end

  // control travels alongside the lanes
  for (genvar s = 0; s < QW; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) cp[s+1] <= '0;
      else if (en) cp[s+1] <= cp[s];
    end
  end

  mi3_merge u_merge (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .ctl (cp[QW]),
    .res (res),
    .out (out)
  );

`ifndef SYNTHESIS
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.singular |-> out.out_r0c0 == '0 && out.out_r1c1 == '0 &&
    out.out_r2c2 == '0 && out.out_r0c2 == '0 && out.out_r2c0 == '0)
    else $error("singular result with nonzero element");
  a_ready_free: assert property (@(posedge clk) !out.valid |-> in.ready)
    else $error("input stalled with empty output");
  a_reset_empty: assert property (@(posedge clk) rst |=> !out.valid)
    else $error("result after reset");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |-> !in.ready)
    else $error("input taken while pipeline stalled");
`endif

endmodule
`default_nettype wire

// File: test/tb_matrix_3x3_inverse_core.sv
`timescale 1ns / 1ps
module tb_matrix_3x3_inverse_core;

  logic clk;
  logic rst;

  mi3_in_if  in_ch ();
  mi3_out_if out_ch ();
  mi3_cfg_if cfg_ch ();

  matrix_3x3_inverse_core DUT (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch),
    .cfg (cfg_ch)
  );

  typedef logic [8:0][31:0] matrix_t;

  typedef struct packed {
    logic             singular;
    logic [8:0][31:0] m;
  } inverse_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  matrix_t  matrices_to_send [$];
  inverse_t inverses_due [$];
  logic [30:0] cur_floor;
  bit quiet;
  int fails, n_sent, n_checked, n_singular, n_sat, cycles;
  int src_gap, snk_gap;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [127:0] cofactor(matrix_t m, int p, int q, int r, int s);
    logic signed [127:0] x0, x1, x2, x3;
    x0 = $signed(m[p]);
    x1 = $signed(m[q]);
    x2 = $signed(m[r]);
    x3 = $signed(m[s]);
    return x0 * x1 - x2 * x3;
  endfunction

  // adjugate over determinant, rounded half away from zero, saturated
  function automatic inverse_t invert(matrix_t m, logic [30:0] floor_q);
    inverse_t res;
    logic signed [127:0] adj [9];
    logic signed [127:0] det, a, b, c;
    logic [127:0] dabs, fl, mag, num, quo, lim;
    bit neg;
    adj[0] = cofactor(m, 4, 8, 5, 7);
    adj[1] = cofactor(m, 2, 7, 1, 8);
    adj[2] = cofactor(m, 1, 5, 2, 4);
    adj[3] = cofactor(m, 5, 6, 3, 8);
    adj[4] = cofactor(m, 0, 8, 2, 6);
    adj[5] = cofactor(m, 2, 3, 0, 5);
    adj[6] = cofactor(m, 3, 7, 4, 6);
    adj[7] = cofactor(m, 1, 6, 0, 7);
    adj[8] = cofactor(m, 0, 4, 1, 3);
    a = $signed(m[0]);
    b = $signed(m[1]);
    c = $signed(m[2]);
    det = a * adj[0] + b * adj[3] + c * adj[6];
    dabs = (det < 0) ? -det : det;
    fl = {97'd0, floor_q} << 32;
    res = '0;
    if (dabs <= fl) begin
      res.singular = 1'b1;
      return res;
    end
    for (int k = 0; k < 9; k++) begin
      mag = (adj[k] < 0) ? -adj[k] : adj[k];
      num = (mag << 33) + dabs;
      quo = num / (dabs << 1);
      neg = (adj[k] < 0) != (det < 0);
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (quo > lim) quo = lim;
      res.m[k] = neg ? 32'(-quo) : quo[31:0];
    end
    return res;
  endfunction

  // sender side
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        inverses_due.push_back(invert({in_ch.in_r2c2, in_ch.in_r2c1, in_ch.in_r2c0,
                                       in_ch.in_r1c2, in_ch.in_r1c1, in_ch.in_r1c0,
                                       in_ch.in_r0c2, in_ch.in_r0c1, in_ch.in_r0c0},
                                      cur_floor));
        n_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (matrices_to_send.size() > 0) begin
          matrix_t mm;
          mm = matrices_to_send.pop_front();
          {in_ch.in_r2c2, in_ch.in_r2c1, in_ch.in_r2c0,
           in_ch.in_r1c2, in_ch.in_r1c1, in_ch.in_r1c0,
           in_ch.in_r0c2, in_ch.in_r0c1, in_ch.in_r0c0} <= mm;
          in_ch.valid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 4);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        inverse_t got, want;
        got.singular = out_ch.singular;
        got.m = {out_ch.out_r2c2, out_ch.out_r2c1, out_ch.out_r2c0,
                 out_ch.out_r1c2, out_ch.out_r1c1, out_ch.out_r1c0,
                 out_ch.out_r0c2, out_ch.out_r0c1, out_ch.out_r0c0};
        if (inverses_due.size() == 0) begin
          $display("%0t: unexpected result, got singular=%0b %h", $time, got.singular, got.m);
          fails++;
        end else begin
          want = inverses_due.pop_front();
          n_checked++;
          if (want.singular) n_singular++;
          if (got.singular !== want.singular) begin
            $display("%0t: singular expected %0b actual %0b", $time, want.singular, got.singular);
            fails++;
          end
          for (int k = 0; k < 9; k++) begin
            if (want.m[k] == 32'h7FFF_FFFF || want.m[k] == 32'h8000_0000) n_sat++;
            if (got.m[k] !== want.m[k]) begin
              $display("%0t: out_r%0dc%0d expected %h actual %h", $time, k / 3, k % 3,
                       want.m[k], got.m[k]);
              fails++;
            end
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) snk_gap <= $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, inverses_due.size());
      $display("[matrix_3x3_inverse_core] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand_elem(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                             : 32'h8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t mm;
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++)
      mm[k] = (kind < 3) ? rand_elem(0) : (kind < 7) ? rand_elem(1) :
              (kind < 8) ? rand_elem(2) : rand_elem($urandom_range(0, 3));
    // near-dependent third row
    if ($urandom_range(0, 4) == 0)
      for (int k = 6; k < 9; k++)
        mm[k] = mm[k - 6] + mm[k - 3] + rand_elem(2);
    return mm;
  endfunction

  task automatic write_floor(logic [30:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.det_floor <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_floor = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (matrices_to_send.size() > 0 || inverses_due.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_random(int n);
    repeat (n) matrices_to_send.push_back(rand_matrix());
  endtask

  localparam logic [31:0] ONE = 32'h0001_0000;

  initial begin
    matrix_t mm;
    rst = 1'b1;
    quiet = 1'b0;
    cur_floor = '0;
    in_ch.valid = 1'b0;
    {in_ch.in_r2c2, in_ch.in_r2c1, in_ch.in_r2c0, in_ch.in_r1c2, in_ch.in_r1c1,
     in_ch.in_r1c0, in_ch.in_r0c2, in_ch.in_r0c1, in_ch.in_r0c0} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.det_floor = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_floor(31'd0);
    // identity, zero, a scaled diagonal
    matrices_to_send.push_back({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
    matrices_to_send.push_back('0);
    matrices_to_send.push_back({32'h0002_0000, 32'd0, 32'd0, 32'd0, 32'hFFFC_0000, 32'd0,
                                32'd0, 32'd0, 32'h0000_8000});
    // tiny diagonal: inverse saturates both ways
    matrices_to_send.push_back({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
    matrices_to_send.push_back({32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0,
                                32'd0, 32'd0, 32'd1});
    // all extremes, rank one
    matrices_to_send.push_back({9{32'h8000_0000}});
    matrices_to_send.push_back({9{32'h7FFF_FFFF}});
    // extreme diagonal and tridiagonal
    matrices_to_send.push_back({32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0,
                                32'd0, 32'd0, 32'h8000_0000});
    matrices_to_send.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h8000_0000,
                                32'h7FFF_FFFF});
    // rounding of thirds: diag 3.0 gives 1/3, raw diag entries 3 and -3 give large thirds
    matrices_to_send.push_back({32'h0003_0000, 32'd0, 32'd0, 32'd0, 32'h0003_0000, 32'd0,
                                32'd0, 32'd0, 32'h0003_0000});
    matrices_to_send.push_back({32'd3, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFD, 32'd0,
                                32'd0, 32'd0, ONE});
    // permutation with negative determinant
    matrices_to_send.push_back({32'd0, 32'd0, ONE, 32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0});
    // dependent rows
    matrices_to_send.push_back({32'h0009_0000, 32'h0007_0000, 32'h0005_0000,
                                32'h0006_0000, 32'h0005_0000, 32'h0004_0000,
                                32'h0003_0000, 32'h0002_0000, ONE});
    repeat (10) matrices_to_send.push_back(rand_matrix());
    push_random(330);
    wait_idle();

    write_floor(31'h7FFF_FFFF);
    matrices_to_send.push_back({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
    push_random(350);
    wait_idle();

    // floor at exactly one: identity is singular, slightly above is not
    write_floor(31'h0001_0000);
    matrices_to_send.push_back({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
    matrices_to_send.push_back({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0,
                                32'h0001_0001});
    push_random(200);
    wait_idle();

    write_floor(31'($urandom_range(0, 32'h00FF_FFFF)));
    push_random(150);
    wait_idle();

    quiet = 1'b1;
    write_floor(31'd1);
    push_random(350);
    wait_idle();

    $display("checked %0d inverses over %0d matrices sent, %0d singular",
             n_checked, n_sent, n_singular);
    $display("%0d saturated elements, %0d det_floor settings", n_sat, 5);
    if (fails == 0) begin
      $display("[matrix_3x3_inverse_core] OK");
    end else begin
      $display("%0d mismatches", fails);
      $display("[matrix_3x3_inverse_core] ERROR");
    end
    $finish;
  end

endmodule
